/* rtl/core/chtwr_pkg.sv */
// Shared definitions for the coalesced hash table: field widths, status and
// action codes, datapath command codes and the datapath status bundle.
// No dependencies.
package chtwr_pkg;

  localparam int KEY_W    = 31;
  localparam int VAL_W    = 16;
  localparam int STATUS_W = 2;
  localparam int SLOT_W   = 4;
  localparam int STEPS_W  = 4;

  localparam logic [STATUS_W-1:0] ST_INSERTED  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FOUND     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_SEARCH = 1'b1;

  // One command per cycle from the controller to the datapath.
  typedef enum logic [4:0] {
    OP_NOP,
    OP_CLEAR,
    OP_ACCEPT,
    OP_READ_HOME,
    OP_SRCH_NEXT,
    OP_RES_FOUND,
    OP_RES_MISS,
    OP_RES_FULL,
    OP_PUT_HOME,
    OP_OCC_HASH,
    OP_WALK_START,
    OP_WALK_NEXT,
    OP_PROBE_END,
    OP_PROBE_REPL,
    OP_PROBE_RD,
    OP_FREE_FOUND,
    OP_WR_NEW_FREE,
    OP_WR_LINK_END,
    OP_WR_MOVE,
    OP_SCAN_RD,
    OP_SCAN_CHK_RD,
    OP_SCAN_CHK,
    OP_OUT_LOAD
  } dp_op_t;

  typedef struct packed {
    logic mod_done;     // modulo unit finished this cycle
    logic is_search;    // latched action is a search
    logic rd_used;      // read record is occupied
    logic key_match;    // read record key equals latched key
    logic rd_has_next;  // read record carries a link
    logic home_eq;      // modulo result equals latched home slot
    logic cnt_full;     // counter reached table size
    logic clr_last;     // counter at last slot
  } dp_stat_t;

endpackage

/* rtl/core/chtwr_mod.sv */
// Modulo unit: key mod TABLE_SIZE by reciprocal multiplication in registered steps.
// Depends on chtwr_pkg.
module chtwr_mod #(
  parameter int TABLE_SIZE = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [chtwr_pkg::KEY_W-1:0]   operand,
  output logic                          done,
  output logic [$clog2(TABLE_SIZE)-1:0] rem
);
  import chtwr_pkg::*;

  localparam int IW = $clog2(TABLE_SIZE);
  localparam int MW = 32;
  localparam int PW = KEY_W + MW;
  localparam int SH = KEY_W + IW;
  // ceil(2^SH / TABLE_SIZE) yields the exact quotient for every KEY_W-bit key
  localparam logic [MW-1:0] MAGIC =
    MW'(((64'd1 << SH) + 64'(TABLE_SIZE) - 64'd1) / 64'(TABLE_SIZE));
  localparam logic [IW:0]   TS_W  = (IW + 1)'(TABLE_SIZE);

  logic [KEY_W-1:0]  opnd;
  logic [PW-1:0]     prod;
  logic [KEY_W-1:0]  quo;
  logic [KEY_W+IW:0] qm;
  logic [KEY_W-1:0]  diff;
  logic [2:0]        stage;

  always_comb begin
    quo  = KEY_W'(prod >> SH);
    diff = opnd - qm[KEY_W-1:0];
  end

  // advance through multiply, back-multiply and subtract
  always_ff @(posedge clk) begin
    if (rst) begin
      stage <= '0;
      done  <= 1'b0;
    end else begin
      stage <= {stage[1:0], start};
      done  <= stage[2];
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      opnd <= operand;
    end
    if (stage[0]) begin
      prod <= opnd * MAGIC;
    end
    if (stage[1]) begin
      qm <= quo * TS_W;
    end
    if (stage[2]) begin
      rem <= diff[IW-1:0];
    end
  end

endmodule

/* rtl/core/chtwr_datapath.sv */
// Datapath of the hash table: slot memory, walk and probe pointers, result
// and output registers; executes one controller command per cycle.
// Depends on chtwr_pkg and chtwr_mod.
module chtwr_datapath #(
  parameter int TABLE_SIZE = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  chtwr_pkg::dp_op_t               op,
  input  logic                            action,
  input  logic [chtwr_pkg::KEY_W-1:0]     key,
  input  logic [chtwr_pkg::VAL_W-1:0]     value,
  output chtwr_pkg::dp_stat_t             stat,
  output logic [chtwr_pkg::STATUS_W-1:0]  status,
  output logic [chtwr_pkg::SLOT_W-1:0]    slot_index,
  output logic [chtwr_pkg::VAL_W-1:0]     found_value,
  output logic [chtwr_pkg::STEPS_W-1:0]   link_steps
);
  import chtwr_pkg::*;

  localparam int IW = $clog2(TABLE_SIZE);
  localparam int CW = $clog2(TABLE_SIZE + 1);
  localparam logic [IW-1:0] LAST_SLOT = IW'(TABLE_SIZE - 1);
  localparam logic [CW-1:0] CNT_FULL  = CW'(TABLE_SIZE);
  localparam logic [CW-1:0] CNT_LAST  = CW'(TABLE_SIZE - 1);

  typedef struct packed {
    logic             used;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] val;
    logic             has_next;
    logic [IW-1:0]    nxt;
  } rec_t;

  function automatic logic [IW-1:0] inc_wrap(input logic [IW-1:0] a);
    inc_wrap = (a == LAST_SLOT) ? '0 : a + 1'b1;
  endfunction

  rec_t mem [TABLE_SIZE];
  rec_t rdata;
  logic [IW-1:0] rslot;

  logic          we, re;
  logic [IW-1:0] waddr, raddr;
  rec_t          wdata, new_rec, linked, redirect;
  logic          redirect_hit;

  logic             action_r;
  logic [KEY_W-1:0] key_r;
  logic [VAL_W-1:0] val_r;
  logic [CW-1:0]    cnt;
  logic [STEPS_W-1:0] steps;
  logic [IW-1:0]    home, end_slot, free_slot, ptr;
  rec_t             occ;

  logic [STATUS_W-1:0] res_status;
  logic [IW-1:0]       res_slot;
  logic [VAL_W-1:0]    res_val;
  logic [STEPS_W-1:0]  res_steps;

  logic             mod_start, mod_done;
  logic [KEY_W-1:0] mod_operand;
  logic [IW-1:0]    mod_rem;

  chtwr_mod #(.TABLE_SIZE(TABLE_SIZE)) u_mod (
    .clk     (clk),
    .rst     (rst),
    .start   (mod_start),
    .operand (mod_operand),
    .done    (mod_done),
    .rem     (mod_rem)
  );

  assign mod_start   = (op == OP_ACCEPT) || (op == OP_OCC_HASH);
  assign mod_operand = (op == OP_ACCEPT) ? key : rdata.key;

  always_comb begin
    new_rec          = '{used: 1'b1, key: key_r, val: val_r, has_next: 1'b0, nxt: '0};
    linked           = occ;
    linked.has_next  = 1'b1;
    linked.nxt       = free_slot;
    redirect         = rdata;
    redirect.nxt     = free_slot;
    redirect_hit     = rdata.has_next && (rdata.nxt == home);
  end

  // Memory port selection
  always_comb begin
    we    = 1'b0;
    waddr = home;
    wdata = new_rec;
    re    = 1'b0;
    raddr = ptr;
    case (op)
      OP_CLEAR: begin
        we    = 1'b1;
        waddr = cnt[IW-1:0];
        wdata = '0;
      end
      OP_PUT_HOME: begin
        we    = 1'b1;
        waddr = home;
      end
      OP_WR_NEW_FREE: begin
        we    = 1'b1;
        waddr = free_slot;
      end
      OP_WR_LINK_END: begin
        we    = 1'b1;
        waddr = end_slot;
        wdata = linked;
      end
      OP_WR_MOVE: begin
        we    = 1'b1;
        waddr = free_slot;
        wdata = occ;
      end
      OP_SCAN_CHK: begin
        we    = redirect_hit;
        waddr = rslot;
        wdata = redirect;
      end
      OP_SCAN_CHK_RD: begin
        we    = redirect_hit;
        waddr = rslot;
        wdata = redirect;
        re    = 1'b1;
        raddr = cnt[IW-1:0];
      end
      OP_READ_HOME: begin
        re    = 1'b1;
        raddr = mod_rem;
      end
      OP_SRCH_NEXT, OP_WALK_NEXT: begin
        re    = 1'b1;
        raddr = rdata.nxt;
      end
      OP_WALK_START: begin
        re    = 1'b1;
        raddr = home;
      end
      OP_PROBE_RD: begin
        re    = 1'b1;
        raddr = ptr;
      end
      OP_SCAN_RD: begin
        re    = 1'b1;
        raddr = cnt[IW-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
      rslot <= raddr;
    end
  end

  // Counter drives the clearing pass after reset, so it resets
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      case (op)
        OP_CLEAR, OP_SRCH_NEXT, OP_WALK_NEXT, OP_PROBE_RD, OP_SCAN_RD, OP_SCAN_CHK_RD:
          cnt <= cnt + 1'b1;
        OP_ACCEPT, OP_WALK_START, OP_PROBE_END, OP_PROBE_REPL, OP_WR_MOVE:
          cnt <= '0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (op)
      OP_ACCEPT: begin
        action_r <= action;
        key_r    <= key;
        val_r    <= value;
        steps    <= '0;
      end
      OP_READ_HOME: home <= mod_rem;
      OP_SRCH_NEXT: begin
        if (steps != '1) begin
          steps <= steps + 1'b1;
        end
      end
      OP_RES_FOUND: begin
        res_status <= ST_FOUND;
        res_slot   <= rslot;
        res_val    <= rdata.val;
        res_steps  <= steps;
      end
      OP_RES_MISS: begin
        res_status <= ST_NOT_FOUND;
        res_slot   <= '0;
        res_val    <= '0;
        res_steps  <= steps;
      end
      OP_RES_FULL: begin
        res_status <= ST_FULL;
        res_slot   <= '0;
        res_val    <= '0;
        res_steps  <= '0;
      end
      OP_PUT_HOME: begin
        res_status <= ST_INSERTED;
        res_slot   <= home;
        res_val    <= '0;
        res_steps  <= '0;
      end
      OP_WR_NEW_FREE: begin
        res_status <= ST_INSERTED;
        res_slot   <= free_slot;
        res_val    <= '0;
        res_steps  <= '0;
      end
      OP_OCC_HASH: occ <= rdata;
      OP_PROBE_END: begin
        end_slot <= rslot;
        occ      <= rdata;
        ptr      <= inc_wrap(rslot);
      end
      OP_PROBE_REPL: ptr <= inc_wrap(home);
      OP_PROBE_RD:   ptr <= inc_wrap(ptr);
      OP_FREE_FOUND: free_slot <= rslot;
      OP_OUT_LOAD: begin
        status      <= res_status;
        slot_index  <= SLOT_W'(res_slot);
        found_value <= res_val;
        link_steps  <= res_steps;
      end
      default: ;
    endcase
  end

  always_comb begin
    stat.mod_done    = mod_done;
    stat.is_search   = (action_r == ACT_SEARCH);
    stat.rd_used     = rdata.used;
    stat.key_match   = (rdata.key == key_r);
    stat.rd_has_next = rdata.has_next;
    stat.home_eq     = (mod_rem == home);
    stat.cnt_full    = (cnt == CNT_FULL);
    stat.clr_last    = (cnt == CNT_LAST);
  end

endmodule

/* rtl/core/chtwr_ctrl.sv */
// Controller of the hash table: sequences clearing, hashing, chain walk,
// probing, relocation and link scan, and owns both handshakes.
// Depends on chtwr_pkg.
module chtwr_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_stall,
  output logic                 rsp_valid,
  input  logic                 rsp_stall,
  input  chtwr_pkg::dp_stat_t  stat,
  output chtwr_pkg::dp_op_t    op
);
  import chtwr_pkg::*;

  typedef enum logic [15:0] {
    S_CLEAR    = 16'h0001,
    S_IDLE     = 16'h0002,
    S_HASH     = 16'h0004,
    S_SRCH     = 16'h0008,
    S_INS_HOME = 16'h0010,
    S_OCC_HASH = 16'h0020,
    S_WALK     = 16'h0040,
    S_PROBE_GO = 16'h0080,
    S_PROBE    = 16'h0100,
    S_LINK_NEW = 16'h0200,
    S_LINK_END = 16'h0400,
    S_MOVE     = 16'h0800,
    S_SCAN_GO  = 16'h1000,
    S_SCAN     = 16'h2000,
    S_PUT_HOME = 16'h4000,
    S_DONE     = 16'h8000
  } state_t;

  state_t state, state_next;
  logic   repl, repl_next;

  assign req_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    repl_next  = repl;
    op         = OP_NOP;
    case (state)
      S_CLEAR: begin
        op = OP_CLEAR;
        if (stat.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (req_valid) begin
          op         = OP_ACCEPT;
          state_next = S_HASH;
        end
      end
      S_HASH: begin
        if (stat.mod_done) begin
          op         = OP_READ_HOME;
          state_next = stat.is_search ? S_SRCH : S_INS_HOME;
        end
      end
      S_SRCH: begin
        if (stat.rd_used && stat.key_match) begin
          op         = OP_RES_FOUND;
          state_next = S_DONE;
        end else if (!stat.rd_used || !stat.rd_has_next || stat.cnt_full) begin
          op         = OP_RES_MISS;
          state_next = S_DONE;
        end else begin
          op = OP_SRCH_NEXT;
        end
      end
      S_INS_HOME: begin
        if (!stat.rd_used) begin
          op         = OP_PUT_HOME;
          state_next = S_DONE;
        end else begin
          op         = OP_OCC_HASH;
          state_next = S_OCC_HASH;
        end
      end
      S_OCC_HASH: begin
        // same home: extend the chain; other home: evict the occupant
        if (stat.mod_done) begin
          if (stat.home_eq) begin
            op         = OP_WALK_START;
            repl_next  = 1'b0;
            state_next = S_WALK;
          end else begin
            op         = OP_PROBE_REPL;
            repl_next  = 1'b1;
            state_next = S_PROBE_GO;
          end
        end
      end
      S_WALK: begin
        if (stat.rd_has_next && !stat.cnt_full) begin
          op = OP_WALK_NEXT;
        end else begin
          op         = OP_PROBE_END;
          state_next = S_PROBE_GO;
        end
      end
      S_PROBE_GO: begin
        op         = OP_PROBE_RD;
        state_next = S_PROBE;
      end
      S_PROBE: begin
        if (!stat.rd_used) begin
          op         = OP_FREE_FOUND;
          state_next = repl ? S_MOVE : S_LINK_NEW;
        end else if (stat.cnt_full) begin
          op         = OP_RES_FULL;
          state_next = S_DONE;
        end else begin
          op = OP_PROBE_RD;
        end
      end
      S_LINK_NEW: begin
        op         = OP_WR_NEW_FREE;
        state_next = S_LINK_END;
      end
      S_LINK_END: begin
        op         = OP_WR_LINK_END;
        state_next = S_DONE;
      end
      S_MOVE: begin
        op         = OP_WR_MOVE;
        state_next = S_SCAN_GO;
      end
      S_SCAN_GO: begin
        op         = OP_SCAN_RD;
        state_next = S_SCAN;
      end
      S_SCAN: begin
        // check the slot read last cycle while reading the next one
        if (stat.cnt_full) begin
          op         = OP_SCAN_CHK;
          state_next = S_PUT_HOME;
        end else begin
          op = OP_SCAN_CHK_RD;
        end
      end
      S_PUT_HOME: begin
        op         = OP_PUT_HOME;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!rsp_valid || !rsp_stall) begin
          op         = OP_OUT_LOAD;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      repl      <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      repl  <= repl_next;
      if (op == OP_OUT_LOAD) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

/* rtl/core/coalesced_hash_table_with_replacement.sv */
// Coalesced hash table with replacement over TABLE_SIZE slots, one item at a
// time. Every item first hashes its key through a reciprocal-multiply modulo
// unit; a search then reads its home slot and follows one link at a time, and
// an insert into an empty home slot writes it there. An insert that meets an
// occupant hashes that key too and walks its chain and probes for a free slot
// at one slot a cycle; evicting an occupant of another home adds a scan of all
// TABLE_SIZE slots that redirects links. The slot memory has separate read and
// write ports. After reset a clearing pass over all TABLE_SIZE slots runs
// before the first request is taken. A result waits in an output register,
// and the next request is taken while it waits.
module coalesced_hash_table_with_replacement #(
  parameter int TABLE_SIZE = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            req_valid,
  output logic                            req_stall,
  input  logic                            action,
  input  logic [chtwr_pkg::KEY_W-1:0]     key,
  input  logic [chtwr_pkg::VAL_W-1:0]     value,
  output logic                            rsp_valid,
  input  logic                            rsp_stall,
  output logic [chtwr_pkg::STATUS_W-1:0]  status,
  output logic [chtwr_pkg::SLOT_W-1:0]    slot_index,
  output logic [chtwr_pkg::VAL_W-1:0]     found_value,
  output logic [chtwr_pkg::STEPS_W-1:0]   link_steps
);
  import chtwr_pkg::*;

  dp_op_t   op;
  dp_stat_t stat;

  chtwr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .stat      (stat),
    .op        (op)
  );

  chtwr_datapath #(.TABLE_SIZE(TABLE_SIZE)) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .op          (op),
    .action      (action),
    .key         (key),
    .value       (value),
    .stat        (stat),
    .status      (status),
    .slot_index  (slot_index),
    .found_value (found_value),
    .link_steps  (link_steps)
  );

endmodule

/* rtl/core/chtwr_checker.sv */
// Port-level checks for the coalesced hash table, attached by bind.
// Depends on chtwr_pkg and coalesced_hash_table_with_replacement.
module chtwr_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            req_valid,
  input logic                            req_stall,
  input logic                            rsp_valid,
  input logic                            rsp_stall,
  input logic [chtwr_pkg::STATUS_W-1:0]  status,
  input logic [chtwr_pkg::SLOT_W-1:0]    slot_index,
  input logic [chtwr_pkg::VAL_W-1:0]     found_value,
  input logic [chtwr_pkg::STEPS_W-1:0]   link_steps
);
  import chtwr_pkg::*;

  // hold a stalled result
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=>
      rsp_valid && $stable({status, slot_index, found_value, link_steps}))
    else $error("stalled result changed");

  // the block is busy right after a request transfer
  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("request taken while previous one still in work");

  a_insert_fields: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (status == ST_INSERTED || status == ST_FULL) |->
      link_steps == '0 && found_value == '0)
    else $error("insert result carries search fields");

  a_miss_fields: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (status == ST_FULL || status == ST_NOT_FOUND) |->
      slot_index == '0 && found_value == '0)
    else $error("miss result carries slot or value");

endmodule

bind coalesced_hash_table_with_replacement chtwr_checker u_chtwr_checker (.*);
